// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property check failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// File: src/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants of the LIFO stack allocator.
// ----------------------------------------------------------------------------
package lsa_pkg;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 25;
   localparam int PAD_W  = 7;
   localparam int ALIGN_W = 3;
   localparam int STATUS_W = 3;
   localparam int LIVE_OUT_W = 9;
   localparam int REC_W = SIZE_W + PAD_W;

   typedef enum logic [1:0] {
      FUNC_ALLOC  = 2'd0,
      FUNC_RESIZE = 2'd1,
      FUNC_FREE   = 2'd2,
      FUNC_RESET  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_SPACE  = 3'd1,
      STATUS_BOUNDS    = 3'd2,
      STATUS_NOT_TOP   = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_BASE_ADDRESS = 1'b0,
      CSR_CAPACITY     = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

// File: src/lsa_ctrl.sv
// ----------------------------------------------------------------------------
// lsa_ctrl
// Request sequencer: capture and record read, then execute and respond.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsa_ctrl
   import lsa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `ASSERT_PROP(a_load_then_exec, clock, reset, cmd.load |=> cmd.exec)
   `ASSERT_PROP(a_exec_single, clock, reset, cmd.exec |=> !cmd.exec)
   `ASSERT_NEVER(a_load_exec_excl, clock, reset, cmd.load && cmd.exec)

endmodule

// File: src/lsa_dp.sv
// ----------------------------------------------------------------------------
// lsa_dp
// Allocator datapath: config registers, arena state, record stack, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsa_dp
   import lsa_pkg::*;
#(
   parameter int HEADER_BYTES = 16,
   parameter int MAX_LIVE     = 256,
   parameter int ARENA_BITS   = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [1:0]            req_func,
   input  logic [SIZE_W-1:0]     req_request_size,
   input  logic [ALIGN_W-1:0]    req_align_log2,
   input  logic [ADDR_W-1:0]     req_block_address,
   input  logic                  csr_write,
   input  logic [0:0]            csr_index,
   input  logic [ADDR_W-1:0]     csr_data,
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_result_address,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SIZE_W-1:0]     rsp_used_now,
   output logic [LIVE_OUT_W-1:0] rsp_live_blocks,
   output logic [SIZE_W-1:0]     rsp_largest_seen
);

   localparam int IDX_W  = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
   localparam int LIVE_W = $clog2(MAX_LIVE + 1);
   localparam int SUM_W  = SIZE_W + 3;
   localparam logic [ADDR_W:0]   ARENA_LIMIT = (ADDR_W+1)'(1) << ARENA_BITS;
   localparam logic [SUM_W-1:0]  HDR = SUM_W'(HEADER_BYTES);
   localparam logic [LIVE_W-1:0] LIVE_MAX = LIVE_W'(MAX_LIVE);

   logic [ADDR_W-1:0]  base_ff;
   logic [SIZE_W-1:0]  capacity_ff;
   logic [SIZE_W-1:0]  top_ff, top_in;
   logic [LIVE_W-1:0]  live_ff, live_in;
   logic [SIZE_W-1:0]  largest_ff, largest_in;
   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   status_type         rsp_status_ff, rsp_status_in;

   func_type           func_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic [ADDR_W-1:0]  addr_ff;

   logic [REC_W-1:0]   rec_mem [MAX_LIVE];
   logic [REC_W-1:0]   rec_rd_ff;
   logic               rec_we;
   logic [REC_W-1:0]   rec_wr_data;
   logic [IDX_W-1:0]   rd_idx;
   logic [IDX_W-1:0]   wr_idx;
   logic [LIVE_W-1:0]  live_minus1;

   logic [SIZE_W-1:0]  cap_eff;
   logic [ADDR_W-1:0]  abs_top;
   logic [PAD_W-1:0]   align_mask;
   logic [PAD_W-1:0]   pad;
   logic [SUM_W-1:0]   alloc_user_off;
   logic [SUM_W-1:0]   rec_user_off;
   logic               alloc_fits;
   logic               resize_fits;
   logic               out_of_bounds;
   logic               is_top;
   logic               full;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         capacity_ff <= SIZE_W'(1 << 24);
      end else if (csr_write) begin
         if (csr_index == CSR_BASE_ADDRESS) begin
            base_ff <= csr_data;
         end
         if (csr_index == CSR_CAPACITY) begin
            capacity_ff <= csr_data[SIZE_W-1:0];
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= func_type'(req_func);
         size_ff  <= req_request_size;
         align_ff <= req_align_log2;
         addr_ff  <= req_block_address;
      end
   end

   // record stack
   assign live_minus1 = live_ff - LIVE_W'(1);
   assign rd_idx      = live_minus1[IDX_W-1:0];
   assign wr_idx      = live_ff[IDX_W-1:0];
   assign rec_wr_data = {pad, top_ff};

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[wr_idx] <= rec_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rec_rd_ff <= rec_mem[rd_idx];
      end
   end

   // checks
   always_comb begin
      cap_eff = (ADDR_W+1)'(capacity_ff) > ARENA_LIMIT ? ARENA_LIMIT[SIZE_W-1:0]
                                                        : capacity_ff;
      abs_top        = base_ff + ADDR_W'(top_ff);
      align_mask     = PAD_W'((8'd1 << align_ff) - 8'd1);
      pad            = (~abs_top[PAD_W-1:0] + PAD_W'(1)) & align_mask;
      alloc_user_off = SUM_W'(top_ff) + SUM_W'(pad) + HDR;
      rec_user_off   = SUM_W'(rec_rd_ff[SIZE_W-1:0]) + SUM_W'(rec_rd_ff[REC_W-1:SIZE_W])
                       + HDR;
      alloc_fits     = (alloc_user_off + SUM_W'(size_ff)) <= SUM_W'(cap_eff);
      resize_fits    = (rec_user_off + SUM_W'(size_ff)) <= SUM_W'(cap_eff);
      out_of_bounds  = (addr_ff < base_ff) ||
                       ((ADDR_W+1)'(addr_ff) >
                        ((ADDR_W+1)'(base_ff) + (ADDR_W+1)'(cap_eff)));
      is_top         = (live_ff != '0) &&
                       (addr_ff == (base_ff + ADDR_W'(rec_user_off)));
      full           = (live_ff == LIVE_MAX);
   end

   // execute
   always_comb begin
      top_in        = top_ff;
      live_in       = live_ff;
      largest_in    = largest_ff;
      rsp_addr_in   = '0;
      rsp_status_in = STATUS_OK;
      rec_we        = 1'b0;
      if (cmd.exec) begin
         unique case (func_ff)
            FUNC_ALLOC: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else if (!alloc_fits) begin
                  rsp_status_in = STATUS_NO_SPACE;
               end else begin
                  rec_we      = 1'b1;
                  live_in     = live_ff + LIVE_W'(1);
                  top_in      = SIZE_W'(alloc_user_off + SUM_W'(size_ff));
                  largest_in  = (size_ff > largest_ff) ? size_ff : largest_ff;
                  rsp_addr_in = base_ff + ADDR_W'(alloc_user_off);
               end
            end
            FUNC_RESIZE: begin
               if (out_of_bounds) begin
                  rsp_status_in = STATUS_BOUNDS;
               end else if (!is_top) begin
                  rsp_status_in = STATUS_NOT_TOP;
               end else if (!resize_fits) begin
                  rsp_status_in = STATUS_NO_SPACE;
               end else begin
                  top_in      = SIZE_W'(rec_user_off + SUM_W'(size_ff));
                  rsp_addr_in = addr_ff;
               end
            end
            FUNC_FREE: begin
               if (out_of_bounds) begin
                  rsp_status_in = STATUS_BOUNDS;
               end else if (!is_top) begin
                  rsp_status_in = STATUS_NOT_TOP;
               end else begin
                  live_in = live_minus1;
                  top_in  = rec_rd_ff[SIZE_W-1:0];
               end
            end
            FUNC_RESET: begin
               top_in     = '0;
               live_in    = '0;
               largest_in = '0;
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         live_ff      <= '0;
         largest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         live_ff      <= live_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_used_now       = top_ff;
   assign rsp_live_blocks    = LIVE_OUT_W'(live_ff);
   assign rsp_largest_seen   = largest_ff;

   `ASSERT_NEVER(a_live_bound, clock, reset, live_ff > LIVE_MAX)
   `ASSERT_PROP(a_rsp_follows_exec, clock, reset, cmd.exec |=> rsp_valid_ff)
   `ASSERT_PROP(a_fail_keeps_live, clock, reset,
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> $stable(live_ff))
   `ASSERT_PROP(a_idle_keeps_top, clock, reset, !cmd.exec |=> $stable(top_ff))

endmodule

// File: src/lifo_stack_allocator.sv
// ----------------------------------------------------------------------------
// lifo_stack_allocator
// LIFO arena allocator with alignment headers and a record stack.
// ----------------------------------------------------------------------------
// Usage: drive req_* and raise start while busy is low; the request is taken
// at that edge. Each request has a capture step, which also reads the top
// record from the record stack memory, and an execute step, which checks and
// updates the arena state. rsp_valid is registered from the execute step and
// pulses for one cycle, carrying result address, status and the usage
// counters as they stand after the request. busy is high during the execute
// step, so no new request is taken until the current one has executed.
// The receiver cannot stall: each response is shown for one cycle only.
// Configuration (csr_index 0 base address, 1 capacity) is written through
// csr_valid/csr_ready, ready while the block is idle.
// Reset clears the arena state and loads base 0, capacity 16 MiB; the record
// stack needs no clearing, since only entries below the live count are read.
// ----------------------------------------------------------------------------
module lifo_stack_allocator
   import lsa_pkg::*;
#(
   parameter int HEADER_BYTES = 16,
   parameter int MAX_LIVE     = 256,
   parameter int ARENA_BITS   = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_func,
   input  logic [SIZE_W-1:0]     req_request_size,
   input  logic [ALIGN_W-1:0]    req_align_log2,
   input  logic [ADDR_W-1:0]     req_block_address,
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_result_address,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SIZE_W-1:0]     rsp_used_now,
   output logic [LIVE_OUT_W-1:0] rsp_live_blocks,
   output logic [SIZE_W-1:0]     rsp_largest_seen,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [ADDR_W-1:0]     csr_data
);

   cmd_type cmd;

   assign csr_ready = !busy;

   lsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   lsa_dp #(
      .HEADER_BYTES (HEADER_BYTES),
      .MAX_LIVE     (MAX_LIVE),
      .ARENA_BITS   (ARENA_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_func           (req_func),
      .req_request_size   (req_request_size),
      .req_align_log2     (req_align_log2),
      .req_block_address  (req_block_address),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .rsp_used_now       (rsp_used_now),
      .rsp_live_blocks    (rsp_live_blocks),
      .rsp_largest_seen   (rsp_largest_seen)
   );

endmodule

// File: tb/lifo_stack_allocator_tb.sv
// ----------------------------------------------------------------------------
// lifo_stack_allocator_tb
// Drives allocate, resize, free and reset requests into the LIFO stack
// allocator under several arena settings and checks every reply, field by
// field, against an in-bench arena tracker updated on each accepted beat.
// ----------------------------------------------------------------------------
module lifo_stack_allocator_tb
   import lsa_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 20;
   localparam int HEADER_BYTES    = 16;
   localparam int MAX_LIVE        = 256;
   localparam int ARENA_BITS      = 24;
   localparam int FULL_ARENA      = 1 << ARENA_BITS;
   localparam int ITEMS_PER_PHASE = 38;
   localparam int PHASES          = 7;
   localparam int STALL_LIMIT     = 1000;

   typedef struct packed {
      func_type              func;
      logic [SIZE_W-1:0]     size;
      logic [ALIGN_W-1:0]    alog;
      logic [ADDR_W-1:0]     addr;
   } alloc_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]     addr;
      status_type            status;
      logic [SIZE_W-1:0]     used;
      logic [LIVE_OUT_W-1:0] live;
      logic [SIZE_W-1:0]     largest;
   } alloc_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_func = '0;
   logic [SIZE_W-1:0]     req_request_size = '0;
   logic [ALIGN_W-1:0]    req_align_log2 = '0;
   logic [ADDR_W-1:0]     req_block_address = '0;
   logic                  rsp_valid;
   logic [ADDR_W-1:0]     rsp_result_address;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SIZE_W-1:0]     rsp_used_now;
   logic [LIVE_OUT_W-1:0] rsp_live_blocks;
   logic [SIZE_W-1:0]     rsp_largest_seen;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [0:0]            csr_index = '0;
   logic [ADDR_W-1:0]     csr_data = '0;

   // arena tracker
   logic [ADDR_W-1:0]     ar_base;
   logic [SIZE_W-1:0]     ar_cap;
   logic [SIZE_W-1:0]     ar_top;
   logic [SIZE_W-1:0]     ar_largest;
   logic [LIVE_OUT_W-1:0] ar_live;
   logic [SIZE_W-1:0]     rec_prev_top [MAX_LIVE];
   logic [PAD_W-1:0]      rec_pad [MAX_LIVE];

   alloc_reply_type replies_due [$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  replies_checked = 0;
   int  csr_writes = 0;
   int  stalled_cycles = 0;
   int  status_tally [8];
   bit  sender_steady = 1'b0;

   lifo_stack_allocator #(
      .HEADER_BYTES(HEADER_BYTES),
      .MAX_LIVE(MAX_LIVE),
      .ARENA_BITS(ARENA_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_request_size(req_request_size),
      .req_align_log2(req_align_log2),
      .req_block_address(req_block_address),
      .rsp_valid(rsp_valid),
      .rsp_result_address(rsp_result_address),
      .rsp_status(rsp_status),
      .rsp_used_now(rsp_used_now),
      .rsp_live_blocks(rsp_live_blocks),
      .rsp_largest_seen(rsp_largest_seen),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic longint unsigned eff_cap();
      longint unsigned lim;
      lim = FULL_ARENA;
      if (ar_cap > lim) return lim;
      return ar_cap;
   endfunction

   function automatic longint unsigned top_user_off();
      int unsigned     slot;
      longint unsigned off;
      slot = (ar_live - 1) % MAX_LIVE;
      off = rec_prev_top[slot];
      off = off + rec_pad[slot] + HEADER_BYTES;
      return off;
   endfunction

   function automatic logic [ADDR_W-1:0] top_block_addr();
      longint unsigned a;
      a = ar_base;
      if (ar_live != 0) a = a + top_user_off();
      return a[ADDR_W-1:0];
   endfunction

   function automatic status_type check_top(logic [ADDR_W-1:0] a);
      longint unsigned hi;
      hi = ar_base;
      hi = hi + eff_cap();
      if (a < ar_base || a > hi) return STATUS_BOUNDS;
      if (ar_live == 0 || a != top_block_addr()) return STATUS_NOT_TOP;
      return STATUS_OK;
   endfunction

   function automatic alloc_reply_type arena_apply(alloc_req_type r);
      alloc_reply_type o;
      longint unsigned abs_top;
      longint unsigned pad;
      longint unsigned user_off;
      longint unsigned new_top;
      longint unsigned sum;
      int unsigned     slot;
      o = '0;
      o.status = STATUS_OK;
      case (r.func)
         FUNC_ALLOC: begin
            abs_top = ar_base;
            abs_top = (abs_top + ar_top) & 64'hFFFF_FFFF;
            pad = (64'd0 - abs_top) & ((64'd1 << r.alog) - 64'd1);
            user_off = ar_top;
            user_off = user_off + pad + HEADER_BYTES;
            new_top = user_off + r.size;
            if (ar_live >= MAX_LIVE) begin
               o.status = STATUS_FULL;
            end else if (new_top > eff_cap()) begin
               o.status = STATUS_NO_SPACE;
            end else begin
               slot = ar_live % MAX_LIVE;
               rec_prev_top[slot] = ar_top;
               rec_pad[slot] = pad[PAD_W-1:0];
               ar_live = ar_live + 1;
               ar_top = new_top[SIZE_W-1:0];
               if (r.size > ar_largest) ar_largest = r.size;
               sum = ar_base;
               sum = sum + user_off;
               o.addr = sum[ADDR_W-1:0];
            end
         end
         FUNC_RESIZE: begin
            o.status = check_top(r.addr);
            if (o.status == STATUS_OK) begin
               new_top = top_user_off() + r.size;
               if (new_top > eff_cap()) begin
                  o.status = STATUS_NO_SPACE;
               end else begin
                  ar_top = new_top[SIZE_W-1:0];
                  o.addr = r.addr;
               end
            end
         end
         FUNC_FREE: begin
            o.status = check_top(r.addr);
            if (o.status == STATUS_OK) begin
               ar_live = ar_live - 1;
               ar_top = rec_prev_top[ar_live % MAX_LIVE];
            end
         end
         FUNC_RESET: begin
            ar_top = '0;
            ar_live = '0;
            ar_largest = '0;
         end
      endcase
      o.used = ar_top;
      o.live = ar_live;
      o.largest = ar_largest;
      return o;
   endfunction

   function automatic alloc_req_type pick_item();
      alloc_req_type r;
      int unsigned   roll;
      int unsigned   size_roll;
      int unsigned   nudge;
      roll = $urandom_range(0, 99);
      size_roll = $urandom_range(0, 99);
      nudge = $urandom_range(1, 64);
      r.func = FUNC_ALLOC;
      if (size_roll < 80) r.size = SIZE_W'($urandom_range(0, 64));
      else if (size_roll < 95) r.size = SIZE_W'($urandom_range(0, 4096));
      else r.size = SIZE_W'($urandom_range(0, FULL_ARENA));
      r.alog = ALIGN_W'($urandom_range(0, 7));
      r.addr = $urandom();
      if (roll < 2) begin
         r.func = FUNC_RESET;
      end else if (roll < 8) begin
         r.func = func_type'($urandom_range(0, 2));
      end else if (roll < 14) begin
         if ($urandom_range(0, 1) != 0) r.func = FUNC_RESIZE;
         else r.func = FUNC_FREE;
         if ($urandom_range(0, 1) != 0) r.addr = top_block_addr() + nudge;
         else r.addr = top_block_addr() - nudge;
      end else if (ar_live == 0 || roll < 55) begin
         r.func = FUNC_ALLOC;
      end else begin
         if (roll < 70) r.func = FUNC_RESIZE;
         else r.func = FUNC_FREE;
         r.addr = top_block_addr();
      end
      return r;
   endfunction

   // send one request beat; leave start high for the next one
   task automatic send_req(func_type f, logic [SIZE_W-1:0] size,
                           logic [ALIGN_W-1:0] alog, logic [ADDR_W-1:0] addr);
      alloc_req_type r;
      r.func = f;
      r.size = size;
      r.alog = alog;
      r.addr = addr;
      if (!sender_steady && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_func <= f;
      req_request_size <= size;
      req_align_log2 <= alog;
      req_block_address <= addr;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      replies_due.push_back(arena_apply(r));
      items_sent++;
   endtask

   task automatic drain_replies();
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_arena(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] cap);
      csr_index <= CSR_BASE_ADDRESS;
      csr_data <= base;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      ar_base = base;
      csr_index <= CSR_CAPACITY;
      csr_data <= cap;
      do @(posedge clock); while (!csr_ready);
      ar_cap = cap[SIZE_W-1:0];
      csr_valid <= 1'b0;
      csr_writes += 2;
   endtask

   task automatic test_directed();
      send_req(FUNC_FREE, '0, '0, '0);
      send_req(FUNC_RESIZE, 25'd8, 3'd0, '0);
      send_req(FUNC_FREE, '0, '0, 32'hFFFF_FFFF);
      send_req(FUNC_ALLOC, 25'd0, 3'd0, '0);
      send_req(FUNC_ALLOC, 25'd1, 3'd7, '0);
      send_req(FUNC_ALLOC, 25'd3, 3'd3, '0);
      send_req(FUNC_RESIZE, 25'd5, 3'd0, top_block_addr() + 32'd1);
      send_req(FUNC_RESIZE, 25'd100, 3'd0, top_block_addr());
      send_req(FUNC_RESIZE, SIZE_W'(FULL_ARENA), 3'd0, top_block_addr());
      send_req(FUNC_ALLOC, SIZE_W'(FULL_ARENA), 3'd7, '0);
      send_req(FUNC_FREE, '0, '0, top_block_addr());
      send_req(FUNC_FREE, '0, '0, 32'd16);
      send_req(FUNC_FREE, '0, '0, top_block_addr());
      send_req(FUNC_FREE, '0, '0, top_block_addr());
      send_req(FUNC_ALLOC, 25'd40, 3'd2, '0);
      send_req(FUNC_RESET, '0, '0, '0);
      // fill to one header short of the end, then an empty block right at the end
      send_req(FUNC_ALLOC, SIZE_W'(FULL_ARENA - 32), 3'd0, '0);
      send_req(FUNC_ALLOC, 25'd0, 3'd0, '0);
      send_req(FUNC_ALLOC, 25'd0, 3'd0, '0);
      send_req(FUNC_FREE, '0, '0, 32'h0100_0001);
      send_req(FUNC_FREE, '0, '0, top_block_addr());
      send_req(FUNC_RESIZE, SIZE_W'(FULL_ARENA - 16), 3'd0, top_block_addr());
      send_req(FUNC_RESIZE, 25'd0, 3'd0, top_block_addr());
      send_req(FUNC_RESET, SIZE_W'(FULL_ARENA), 3'd7, 32'hFFFF_FFFF);
   endtask

   task automatic test_record_stack_full();
      repeat (MAX_LIVE) begin
         send_req(FUNC_ALLOC, SIZE_W'($urandom_range(0, 8)),
                  ALIGN_W'($urandom_range(0, 3)), $urandom());
      end
      send_req(FUNC_ALLOC, 25'd0, 3'd0, '0);
      send_req(FUNC_ALLOC, SIZE_W'(FULL_ARENA), 3'd7, '0);
      send_req(FUNC_FREE, '0, '0, top_block_addr());
      send_req(FUNC_ALLOC, 25'd4, 3'd2, '0);
      send_req(FUNC_ALLOC, 25'd4, 3'd2, '0);
      send_req(FUNC_RESIZE, 25'd12, 3'd0, top_block_addr());
      send_req(FUNC_RESET, '0, '0, '0);
   endtask

   task automatic test_random_phases();
      alloc_req_type r;
      for (int p = 0; p < PHASES; p++) begin
         drain_replies();
         case (p)
            0: set_arena(32'h0000_0000, FULL_ARENA);
            1: set_arena(32'hFF00_0000, FULL_ARENA);
            2: set_arena(32'h0123_4567, 32'd4096);
            3: set_arena($urandom_range(0, 32'hFF00_0000), 32'd0);
            4: set_arena(32'h8000_0003, 32'h01FF_FFFF);
            5: set_arena($urandom_range(0, 32'hFF00_0000), $urandom_range(0, FULL_ARENA));
            default: set_arena($urandom_range(0, 32'hFF00_0000), $urandom_range(64, 2048));
         endcase
         sender_steady = (p == 1);
         repeat (ITEMS_PER_PHASE) begin
            r = pick_item();
            send_req(r.func, r.size, r.alog, r.addr);
         end
      end
      sender_steady = 1'b0;
   endtask

   task automatic report_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_replies
      alloc_reply_type want;
      if (!reset && rsp_valid) begin
         if (replies_due.size() == 0) begin
            mismatches++;
            $display("%0t reply with none pending: expected nothing, got status %0d",
                     $time, rsp_status);
         end else begin
            want = replies_due.pop_front();
            report_field("result_address", want.addr, rsp_result_address);
            report_field("status", want.status, rsp_status);
            report_field("used_now", want.used, rsp_used_now);
            report_field("live_blocks", want.live, rsp_live_blocks);
            report_field("largest_seen", want.largest, rsp_largest_seen);
            replies_checked++;
            status_tally[rsp_status]++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("%0t no beat moved for %0d cycles", $time, STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      foreach (status_tally[i]) status_tally[i] = 0;
      ar_base = '0;
      ar_cap = SIZE_W'(FULL_ARENA);
      ar_top = '0;
      ar_live = '0;
      ar_largest = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_record_stack_full();
      test_random_phases();
      drain_replies();
      repeat (4) @(posedge clock);
      $display("%0d requests, %0d replies checked, %0d register writes over %0d arena setups",
               items_sent, replies_checked, csr_writes, PHASES);
      $display("ok %0d, no_space %0d, out_of_bounds %0d, not_top %0d, stack_full %0d",
               status_tally[STATUS_OK], status_tally[STATUS_NO_SPACE],
               status_tally[STATUS_BOUNDS], status_tally[STATUS_NOT_TOP],
               status_tally[STATUS_FULL]);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
